// ----- hw/rtl/numeric_literal_recognizer_top_defines.svh -----
// Assertion macros shared by the numeric literal recognizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef NUMERIC_LITERAL_RECOGNIZER_TOP_DEFINES_SVH
`define NUMERIC_LITERAL_RECOGNIZER_TOP_DEFINES_SVH

// Checked only outside reset.
`define NLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define NLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/nlr_pkg.sv -----
// Package for the numeric literal recognizer: state codes, character
// constants, the item type and the accepting-state function. No dependencies.
`timescale 1ns / 1ps

package nlr_pkg;

  localparam int unsigned StateW = 4;

  // Recognizer state codes
  localparam logic [StateW-1:0] ST_START = 4'd0;  // only spaces so far
  localparam logic [StateW-1:0] ST_MSIGN = 4'd1;  // mantissa sign
  localparam logic [StateW-1:0] ST_MINT  = 4'd2;  // integer digits
  localparam logic [StateW-1:0] ST_MDOT  = 4'd3;  // point, no digit yet
  localparam logic [StateW-1:0] ST_MFRAC = 4'd4;  // point and a digit
  localparam logic [StateW-1:0] ST_EXP   = 4'd5;  // exponent letter
  localparam logic [StateW-1:0] ST_ESIGN = 4'd6;  // exponent sign
  localparam logic [StateW-1:0] ST_EDIG  = 4'd7;  // exponent digits
  localparam logic [StateW-1:0] ST_TRAIL = 4'd8;  // trailing spaces
  localparam logic [StateW-1:0] ST_BAD   = 4'd9;  // invalid, absorbing

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  // One input item
  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
  } nlr_item_t;

  // Item handed to the state machine, with its fire strobe
  typedef struct packed {
    logic      fire;
    nlr_item_t item;
  } nlr_step_t;

  function automatic logic nlr_accepting(input logic [StateW-1:0] s);
    return (s == ST_MINT) || (s == ST_MFRAC) || (s == ST_EDIG) || (s == ST_TRAIL);
  endfunction

endpackage

// ----- hw/rtl/nlr_fsm.sv -----
// Recognizer state machine: state register, transition logic and verdict.
// Depends on nlr_pkg and numeric_literal_recognizer_top_defines.svh.
`timescale 1ns / 1ps
`include "numeric_literal_recognizer_top_defines.svh"

module nlr_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nlr_pkg::nlr_step_t step_i,
  output logic              is_valid_o
);
  import nlr_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic [StateW-1:0] next_s;
  logic [7:0]        c;
  logic              digit, sign, point, expo, space;

  assign c     = step_i.item.character;
  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign sign  = (c == CH_PLUS) || (c == CH_MINUS);
  assign point = (c == CH_POINT);
  assign expo  = (c == CH_E_UP) || (c == CH_E_LO);
  assign space = (c == CH_SPACE);

  // Transition on one character
  always_comb begin
    next_s = ST_BAD;
    if (space) begin
      if (state_q == ST_START) next_s = ST_START;
      else if (nlr_accepting(state_q)) next_s = ST_TRAIL;
      else next_s = ST_BAD;
    end else begin
      unique case (state_q)
        ST_START: begin
          if (sign) next_s = ST_MSIGN;
          else if (digit) next_s = ST_MINT;
          else if (point) next_s = ST_MDOT;
        end
        ST_MSIGN: begin
          if (digit) next_s = ST_MINT;
          else if (point) next_s = ST_MDOT;
        end
        ST_MINT: begin
          if (digit) next_s = ST_MINT;
          else if (point) next_s = ST_MFRAC;
          else if (expo) next_s = ST_EXP;
        end
        ST_MDOT: begin
          if (digit) next_s = ST_MFRAC;
        end
        ST_MFRAC: begin
          if (digit) next_s = ST_MFRAC;
          else if (expo) next_s = ST_EXP;
        end
        ST_EXP: begin
          if (sign) next_s = ST_ESIGN;
          else if (digit) next_s = ST_EDIG;
        end
        ST_ESIGN, ST_EDIG: begin
          if (digit) next_s = ST_EDIG;
        end
        default: next_s = ST_BAD;
      endcase
    end
  end

  // State after this item's character (empty items leave it alone)
  logic [StateW-1:0] post_s;
  assign post_s     = step_i.item.has_char ? next_s : state_q;
  assign is_valid_o = nlr_accepting(post_s);

  // A finished literal returns to start
  always_comb begin
    state_d = state_q;
    if (step_i.fire) begin
      state_d = step_i.item.last ? ST_START : post_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
    end else begin
      state_q <= state_d;
    end
  end

  `NLR_ASSERT(a_state_legal, state_q <= ST_BAD, "state code out of range")
  `NLR_ASSERT(a_last_restarts, step_i.fire && step_i.item.last |=> state_q == ST_START,
              "state not back at start after a literal ended")
  `NLR_ASSERT(a_bad_absorbs, state_q == ST_BAD && !(step_i.fire && step_i.item.last)
              |=> state_q == ST_BAD, "invalid state left before literal end")

endmodule

// ----- hw/rtl/numeric_literal_recognizer_top.sv -----
// Top level of the numeric literal recognizer: input register, output register
// and handshakes. Depends on nlr_pkg, nlr_fsm and the assertion macro header.
`timescale 1ns / 1ps
`include "numeric_literal_recognizer_top_defines.svh"

// Usage:
//   Input channel: one character item per accepted cycle (in_valid_i high,
//   in_stall_o low). has_char_i = 0 marks an item with no character; last_i
//   ends the literal. Only an item with last_i gives a result.
//   Output channel: one is_valid_o item per literal, taken when out_valid_o
//   is high and out_stall_i low.
//   Throughput: one item per clock, sustained, as long as results are taken.
//   Path: a last item goes through the input register, then its result is registered in the output register.
//   The state machine updates in the cycle an item leaves the input register.
//   Stalls: a pending result held by out_stall_i blocks only a following last
//   item in the input register; items without last keep flowing through.
//   Reset (rst_ni low, asynchronous) empties both registers and returns the
//   recognizer to its start state; no result is pending afterwards.
module numeric_literal_recognizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] character_i,
  input  logic       has_char_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_valid_o
);
  import nlr_pkg::*;

  logic      in_vld_q, in_vld_d;
  nlr_item_t in_q;
  logic      out_vld_q, out_vld_d;
  logic      is_valid_q;
  logic      out_free;
  logic      advance;
  logic      in_take;
  logic      verdict;
  nlr_step_t step;

  // Input register moves on unless a result would overwrite a held one
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!in_q.last || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign step.fire = advance;
  assign step.item = in_q;

  nlr_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .is_valid_o(verdict)
  );

  // Valid flags
  always_comb begin
    in_vld_d = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = out_vld_q && out_stall_i;
    if (advance && in_q.last) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.character <= character_i;
      in_q.has_char  <= has_char_i;
      in_q.last      <= last_i;
    end
    if (advance && in_q.last) begin
      is_valid_q <= verdict;
    end
  end

  assign out_valid_o = out_vld_q;
  assign is_valid_o  = is_valid_q;

  `NLR_ASSERT(a_stall_cause, in_stall_o |-> out_vld_q && out_stall_i && in_q.last,
              "input stalled without a held result")
  `NLR_ASSERT(a_nonlast_no_result, out_vld_q && !out_stall_i && !(advance && in_q.last)
              |=> !out_vld_q, "result appeared without a last item")
  `NLR_ASSERT(a_result_held, out_vld_q && out_stall_i |=> out_vld_q && $stable(is_valid_o),
              "stalled result changed or dropped")

endmodule
